>>> sv/tgdi_pkg.sv
// ----------------------------------------------------------------------------
// tgdi_pkg
// Shared widths, mode codes and register indexes for the trilinear grid
// deposit / interpolate engine.
// ----------------------------------------------------------------------------
package tgdi_pkg;

    // Fixed field widths
    localparam int POS_BITS     = 20;
    localparam int VALUE_BITS   = 32;
    localparam int MODE_BITS    = 2;
    localparam int CFG_BITS     = 5;
    localparam int CFG_IDX_BITS = 2;

    // Parameter defaults
    localparam int NODES_DEF = 16;
    localparam int FRAC_DEF  = 16;

    typedef logic [MODE_BITS-1:0]    mode_t;
    typedef logic [CFG_BITS-1:0]     cfg_val_t;
    typedef logic [CFG_IDX_BITS-1:0] cfg_idx_t;

    // Command modes
    localparam mode_t MODE_DEPOSIT = 2'd0;
    localparam mode_t MODE_INTERP  = 2'd1;
    localparam mode_t MODE_CLEAR   = 2'd2;

    // Configuration register indexes
    localparam cfg_idx_t REG_NODES_X = 2'd0;
    localparam cfg_idx_t REG_NODES_Y = 2'd1;
    localparam cfg_idx_t REG_NODES_Z = 2'd2;

    // Node count register value after reset
    localparam cfg_val_t NODES_RESET = 5'd16;

endpackage

>>> sv/trilinear_grid_deposit_interpolate_top.sv
// ----------------------------------------------------------------------------
// trilinear_grid_deposit_interpolate_top
// Cloud-in-cell engine: deposits values onto, or interpolates from, the eight
// nodes around a particle position in a node memory.
// ----------------------------------------------------------------------------
// Usage:
//   A command is taken when start is high and busy is low. It carries mode,
//   the position pos_x/y/z and deposit_value. Each command gives one result
//   transaction: done pulses for one cycle with interp_value and
//   out_of_range; the receiver has no way to stall it.
//   Deposit and interpolate run one setup state, one base address state,
//   then for each of the 8 corners a memory read, three passes through the
//   one shared weight multiplier and an update, set by the single memory
//   port and shared multiplier.
//   busy drops with done, so a new command is taken only after the last
//   one has delivered its result.
//   Out-of-range positions and the unused mode finish in the setup state.
//   Clear zeroes every node of the memory, one node per cycle, before done.
//   After reset the same sweep runs with busy high and no done pulse;
//   configuration writes (cfg_we, cfg_index, cfg_data) are taken at any
//   time and should be issued only while no command is in flight.
// ----------------------------------------------------------------------------
module trilinear_grid_deposit_interpolate_top #(
    parameter int NODES_PER_AXIS = tgdi_pkg::NODES_DEF,
    parameter int FRAC_BITS      = tgdi_pkg::FRAC_DEF
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    start,
    output logic                                    busy,
    input  tgdi_pkg::mode_t                         mode,
    input  logic [tgdi_pkg::POS_BITS-1:0]           pos_x,
    input  logic [tgdi_pkg::POS_BITS-1:0]           pos_y,
    input  logic [tgdi_pkg::POS_BITS-1:0]           pos_z,
    input  logic signed [tgdi_pkg::VALUE_BITS-1:0]  deposit_value,
    output logic                                    done,
    output logic signed [tgdi_pkg::VALUE_BITS-1:0]  interp_value,
    output logic                                    out_of_range,
    input  logic                                    cfg_we,
    input  tgdi_pkg::cfg_idx_t                      cfg_index,
    input  tgdi_pkg::cfg_val_t                      cfg_data
);
    import tgdi_pkg::*;

    // Derived sizes
    localparam int VB    = VALUE_BITS;
    localparam int DEPTH = NODES_PER_AXIS * NODES_PER_AXIS * NODES_PER_AXIS;
    localparam int AW    = $clog2(DEPTH);
    localparam int NW    = $clog2(NODES_PER_AXIS + 1);
    localparam int WW    = FRAC_BITS + 1;
    localparam int PRW   = VB + WW;
    localparam int SW    = VB + 2;
    localparam int ACW   = VB + 4;

    localparam logic [WW-1:0]  ONE_W    = WW'(1) << FRAC_BITS;
    localparam logic [PRW-1:0] HALF     = PRW'(1) << (FRAC_BITS - 1);
    localparam logic [VB-1:0]  MAX_VAL  = {1'b0, {(VB-1){1'b1}}};
    localparam logic [VB-1:0]  MIN_VAL  = {1'b1, {(VB-1){1'b0}}};
    localparam logic [AW-1:0]  LAST_ADR = AW'(DEPTH - 1);

    // Sequencer states
    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_CLEAR = 4'd1;
    localparam logic [3:0] ST_SETUP = 4'd2;
    localparam logic [3:0] ST_BASE  = 4'd3;
    localparam logic [3:0] ST_READ  = 4'd4;
    localparam logic [3:0] ST_MULX  = 4'd5;
    localparam logic [3:0] ST_MULY  = 4'd6;
    localparam logic [3:0] ST_MULZ  = 4'd7;
    localparam logic [3:0] ST_UPD   = 4'd8;

    // Clamp a node count register to [2, NODES_PER_AXIS]
    function automatic logic [NW-1:0] eff_nodes(input cfg_val_t r);
        logic [NW-1:0] res;
        if (r < 5'd2)
            res = NW'(2);
        else if (32'(r) > NODES_PER_AXIS)
            res = NW'(NODES_PER_AXIS);
        else
            res = NW'(r);
        return res;
    endfunction

    // Control registers
    logic [3:0]    state_reg, state_next;
    logic [AW-1:0] clr_cnt_reg, clr_cnt_next;
    logic          clr_cmd_reg, clr_cmd_next;
    logic          done_reg, done_next;
    logic [2:0]    corner_reg, corner_next;
    cfg_val_t      nodes_x_reg, nodes_x_next;
    cfg_val_t      nodes_y_reg, nodes_y_next;
    cfg_val_t      nodes_z_reg, nodes_z_next;

    // Payload registers
    mode_t          mode_reg, mode_next;
    logic [POS_BITS-1:0] pos_x_reg, pos_x_next;
    logic [POS_BITS-1:0] pos_y_reg, pos_y_next;
    logic [POS_BITS-1:0] pos_z_reg, pos_z_next;
    logic [VB-1:0]  val_reg, val_next;
    logic [AW-1:0]  nx_reg, nx_next;
    logic [AW-1:0]  nxny_reg, nxny_next;
    logic [AW-1:0]  iynx_reg, iynx_next;
    logic [AW-1:0]  base_reg, base_next;
    logic [AW-1:0]  addr_reg, addr_next;
    logic [WW-1:0]  wx_lo_reg, wx_lo_next, wx_hi_reg, wx_hi_next;
    logic [WW-1:0]  wy_lo_reg, wy_lo_next, wy_hi_reg, wy_hi_next;
    logic [WW-1:0]  wz_lo_reg, wz_lo_next, wz_hi_reg, wz_hi_next;
    logic [VB-1:0]  mag_reg, mag_next;
    logic           neg_reg, neg_next;
    logic [ACW-1:0] acc_reg, acc_next;
    logic [VB-1:0]  interp_value_reg, interp_value_next;
    logic           out_of_range_reg, out_of_range_next;

    // Node memory
    logic [VB-1:0]  mem [DEPTH];
    logic [VB-1:0]  mem_q_reg;
    logic           mem_we, mem_re;
    logic [AW-1:0]  mem_waddr, mem_raddr;
    logic [VB-1:0]  mem_wdata;

    // Cell indexes and range check
    logic [POS_BITS-1:0] ix_full, iy_full, iz_full;
    logic [NW-1:0]       nx_eff, ny_eff, nz_eff;
    logic                oor;

    assign ix_full = pos_x_reg >> FRAC_BITS;
    assign iy_full = pos_y_reg >> FRAC_BITS;
    assign iz_full = pos_z_reg >> FRAC_BITS;
    assign nx_eff  = eff_nodes(nodes_x_reg);
    assign ny_eff  = eff_nodes(nodes_y_reg);
    assign nz_eff  = eff_nodes(nodes_z_reg);
    assign oor = (32'(ix_full) + 32'd1 >= 32'(nx_eff)) ||
                 (32'(iy_full) + 32'd1 >= 32'(ny_eff)) ||
                 (32'(iz_full) + 32'd1 >= 32'(nz_eff));

    // Corner address
    logic [AW-1:0] corner_addr;
    assign corner_addr = base_reg + AW'(corner_reg[0])
                       + (corner_reg[1] ? nx_reg : '0)
                       + (corner_reg[2] ? nxny_reg : '0);

    // Shared weight multiplier: round(mag * w / 2^F), half away from zero
    logic [VB-1:0]  src, src_mag;
    logic           src_neg;
    logic [VB-1:0]  mul_mag;
    logic [WW-1:0]  mul_w;
    logic [PRW-1:0] prod, rnd;
    logic [VB-1:0]  mul_res;

    assign src     = (mode_reg == MODE_DEPOSIT) ? val_reg : mem_q_reg;
    assign src_neg = src[VB-1];
    assign src_mag = src_neg ? (~src + VB'(1)) : src;

    always_comb
    begin
        mul_mag = mag_reg;
        mul_w   = corner_reg[2] ? wz_hi_reg : wz_lo_reg;
        if (state_reg == ST_MULX)
        begin
            mul_mag = src_mag;
            mul_w   = corner_reg[0] ? wx_hi_reg : wx_lo_reg;
        end
        else if (state_reg == ST_MULY)
        begin
            mul_w   = corner_reg[1] ? wy_hi_reg : wy_lo_reg;
        end
    end

    assign prod    = PRW'(mul_mag) * PRW'(mul_w);
    assign rnd     = prod + HALF;
    assign mul_res = rnd[FRAC_BITS +: VB];

    // Deposit update: node + term, saturated
    logic [SW-1:0] term_ext, term_sw, dep_sum;
    logic [VB-1:0] dep_sat;

    assign term_ext = {2'b00, mag_reg};
    assign term_sw  = neg_reg ? (~term_ext + SW'(1)) : term_ext;
    assign dep_sum  = {{2{mem_q_reg[VB-1]}}, mem_q_reg} + term_sw;

    always_comb
    begin
        if (!dep_sum[SW-1] && (|dep_sum[SW-2:VB-1]))
            dep_sat = MAX_VAL;
        else if (dep_sum[SW-1] && !(&dep_sum[SW-2:VB-1]))
            dep_sat = MIN_VAL;
        else
            dep_sat = dep_sum[VB-1:0];
    end

    // Interpolation accumulate, saturated at the end
    logic [ACW-1:0] acc_ext, acc_term, acc_sum;
    logic [VB-1:0]  acc_sat;

    assign acc_ext  = {4'b0000, mag_reg};
    assign acc_term = neg_reg ? (~acc_ext + ACW'(1)) : acc_ext;
    assign acc_sum  = acc_reg + acc_term;

    always_comb
    begin
        if (!acc_sum[ACW-1] && (|acc_sum[ACW-2:VB-1]))
            acc_sat = MAX_VAL;
        else if (acc_sum[ACW-1] && !(&acc_sum[ACW-2:VB-1]))
            acc_sat = MIN_VAL;
        else
            acc_sat = acc_sum[VB-1:0];
    end

    // Configuration writes
    always_comb
    begin
        nodes_x_next = nodes_x_reg;
        nodes_y_next = nodes_y_reg;
        nodes_z_next = nodes_z_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_NODES_X: nodes_x_next = cfg_data;
                REG_NODES_Y: nodes_y_next = cfg_data;
                REG_NODES_Z: nodes_z_next = cfg_data;
                default:     ;
            endcase
        end
    end

    // Sequencer
    always_comb
    begin
        state_next        = state_reg;
        clr_cnt_next      = clr_cnt_reg;
        clr_cmd_next      = clr_cmd_reg;
        done_next         = 1'b0;
        corner_next       = corner_reg;
        mode_next         = mode_reg;
        pos_x_next        = pos_x_reg;
        pos_y_next        = pos_y_reg;
        pos_z_next        = pos_z_reg;
        val_next          = val_reg;
        nx_next           = nx_reg;
        nxny_next         = nxny_reg;
        iynx_next         = iynx_reg;
        base_next         = base_reg;
        addr_next         = addr_reg;
        wx_lo_next        = wx_lo_reg;
        wx_hi_next        = wx_hi_reg;
        wy_lo_next        = wy_lo_reg;
        wy_hi_next        = wy_hi_reg;
        wz_lo_next        = wz_lo_reg;
        wz_hi_next        = wz_hi_reg;
        mag_next          = mag_reg;
        neg_next          = neg_reg;
        acc_next          = acc_reg;
        interp_value_next = interp_value_reg;
        out_of_range_next = out_of_range_reg;
        mem_we            = 1'b0;
        mem_waddr         = addr_reg;
        mem_wdata         = dep_sat;
        mem_re            = 1'b0;
        mem_raddr         = corner_addr;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    mode_next  = mode;
                    pos_x_next = pos_x;
                    pos_y_next = pos_y;
                    pos_z_next = pos_z;
                    val_next   = deposit_value;
                    if (mode == MODE_CLEAR)
                    begin
                        state_next   = ST_CLEAR;
                        clr_cnt_next = '0;
                        clr_cmd_next = 1'b1;
                    end
                    else
                    begin
                        state_next = ST_SETUP;
                    end
                end
            end

            // Zero one node per cycle
            ST_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_cnt_reg;
                mem_wdata = '0;
                if (clr_cnt_reg == LAST_ADR)
                begin
                    state_next = ST_IDLE;
                    if (clr_cmd_reg)
                    begin
                        done_next         = 1'b1;
                        interp_value_next = '0;
                        out_of_range_next = 1'b0;
                    end
                    clr_cmd_next = 1'b0;
                end
                else
                begin
                    clr_cnt_next = clr_cnt_reg + AW'(1);
                end
            end

            // Range check, weights, partial address products
            ST_SETUP:
            begin
                priority if (mode_reg != MODE_DEPOSIT && mode_reg != MODE_INTERP)
                begin
                    state_next        = ST_IDLE;
                    done_next         = 1'b1;
                    interp_value_next = '0;
                    out_of_range_next = 1'b0;
                end
                else if (oor)
                begin
                    state_next        = ST_IDLE;
                    done_next         = 1'b1;
                    interp_value_next = '0;
                    out_of_range_next = 1'b1;
                end
                else
                begin
                    state_next = ST_BASE;
                    nx_next    = AW'(nx_eff);
                    nxny_next  = AW'(nx_eff) * AW'(ny_eff);
                    iynx_next  = AW'(iy_full) * AW'(nx_eff);
                    wx_hi_next = WW'(FRAC_BITS'(pos_x_reg));
                    wx_lo_next = ONE_W - WW'(FRAC_BITS'(pos_x_reg));
                    wy_hi_next = WW'(FRAC_BITS'(pos_y_reg));
                    wy_lo_next = ONE_W - WW'(FRAC_BITS'(pos_y_reg));
                    wz_hi_next = WW'(FRAC_BITS'(pos_z_reg));
                    wz_lo_next = ONE_W - WW'(FRAC_BITS'(pos_z_reg));
                end
            end

            ST_BASE:
            begin
                base_next   = AW'(ix_full) + iynx_reg + AW'(iz_full) * nxny_reg;
                acc_next    = '0;
                corner_next = 3'd0;
                state_next  = ST_READ;
            end

            ST_READ:
            begin
                mem_re     = 1'b1;
                addr_next  = corner_addr;
                state_next = ST_MULX;
            end

            ST_MULX:
            begin
                mag_next   = mul_res;
                neg_next   = src_neg;
                state_next = ST_MULY;
            end

            ST_MULY:
            begin
                mag_next   = mul_res;
                state_next = ST_MULZ;
            end

            ST_MULZ:
            begin
                mag_next   = mul_res;
                state_next = ST_UPD;
            end

            // Write back the node or add the term
            ST_UPD:
            begin
                if (mode_reg == MODE_DEPOSIT)
                    mem_we = 1'b1;
                else
                    acc_next = acc_sum;
                if (corner_reg == 3'd7)
                begin
                    state_next        = ST_IDLE;
                    done_next         = 1'b1;
                    out_of_range_next = 1'b0;
                    interp_value_next = (mode_reg == MODE_INTERP) ? acc_sat : '0;
                end
                else
                begin
                    corner_next = corner_reg + 3'd1;
                    state_next  = ST_READ;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_CLEAR;
            clr_cnt_reg <= '0;
            clr_cmd_reg <= 1'b0;
            done_reg    <= 1'b0;
            corner_reg  <= 3'd0;
            nodes_x_reg <= NODES_RESET;
            nodes_y_reg <= NODES_RESET;
            nodes_z_reg <= NODES_RESET;
        end
        else
        begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
            clr_cmd_reg <= clr_cmd_next;
            done_reg    <= done_next;
            corner_reg  <= corner_next;
            nodes_x_reg <= nodes_x_next;
            nodes_y_reg <= nodes_y_next;
            nodes_z_reg <= nodes_z_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        mode_reg         <= mode_next;
        pos_x_reg        <= pos_x_next;
        pos_y_reg        <= pos_y_next;
        pos_z_reg        <= pos_z_next;
        val_reg          <= val_next;
        nx_reg           <= nx_next;
        nxny_reg         <= nxny_next;
        iynx_reg         <= iynx_next;
        base_reg         <= base_next;
        addr_reg         <= addr_next;
        wx_lo_reg        <= wx_lo_next;
        wx_hi_reg        <= wx_hi_next;
        wy_lo_reg        <= wy_lo_next;
        wy_hi_reg        <= wy_hi_next;
        wz_lo_reg        <= wz_lo_next;
        wz_hi_reg        <= wz_hi_next;
        mag_reg          <= mag_next;
        neg_reg          <= neg_next;
        acc_reg          <= acc_next;
        interp_value_reg <= interp_value_next;
        out_of_range_reg <= out_of_range_next;
    end

    // Node memory, registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        if (mem_re)
            mem_q_reg <= mem[mem_raddr];
    end

    // Outputs
    assign busy         = (state_reg != ST_IDLE);
    assign done         = done_reg;
    assign interp_value = $signed(interp_value_reg);
    assign out_of_range = out_of_range_reg;

`ifndef NO_ASSERTIONS
    // A result only follows work
    a_done_after_work: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> ($past(state_reg) != ST_IDLE))
        else $error("done without a command in flight");

    // An accepted command makes the block busy
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("command accepted but block not busy");

    // Flagged items carry a zero value
    a_oor_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && out_of_range_reg) |-> (interp_value_reg == '0))
        else $error("out-of-range result with nonzero value");

    // The last corner update ends the command
    a_last_corner_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_UPD && corner_reg == 3'd7) |=> (done_reg && !busy))
        else $error("last corner did not deliver a result");
`endif

endmodule

>>> test/trilinear_grid_deposit_interpolate_top_tb.sv
// ----------------------------------------------------------------------------
// trilinear_grid_deposit_interpolate_top_tb
// Self-checking bench for the cloud-in-cell grid engine. A short directed
// table covers empty and saturated nodes, extreme positions and values,
// rounding ties, clear, the unused mode, last-node flagging and register
// clamping. Random phases follow, each with its own grid size and sender
// idling. A local model of the node store predicts every untyped result.
// ----------------------------------------------------------------------------
module trilinear_grid_deposit_interpolate_top_tb;

    import tgdi_pkg::*;

    localparam int HALF_PERIOD    = 5;
    localparam int FRAC           = FRAC_DEF;
    localparam int CELL_BITS      = POS_BITS - FRAC;
    localparam int STORE_DEPTH    = NODES_DEF * NODES_DEF * NODES_DEF;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES   = 100;
    localparam int NUM_PHASES     = 8;
    localparam int ITEMS_PER_PHASE = 113;

    localparam longint VAL_HI = (longint'(1) << (VALUE_BITS - 1)) - 1;
    localparam longint VAL_LO = -VAL_HI - 1;

    // Codes the package leaves unnamed
    localparam mode_t    MODE_UNUSED = 2'd3;
    localparam cfg_idx_t REG_UNUSED  = 2'd3;

    // Handy positions and values for the directed table
    localparam logic [POS_BITS-1:0] ORIGIN   = 20'h00000;
    localparam logic [POS_BITS-1:0] ONE_CELL = 20'h10000;
    localparam logic [POS_BITS-1:0] MID      = 20'h08000;
    localparam logic [POS_BITS-1:0] NEAR_ONE = 20'h0FFFF;
    localparam logic [POS_BITS-1:0] PMAX     = 20'hEFFFF;
    localparam logic signed [VALUE_BITS-1:0] V0   = 32'sh00000000;
    localparam logic signed [VALUE_BITS-1:0] VMAX = 32'sh7FFFFFFF;
    localparam logic signed [VALUE_BITS-1:0] VMIN = 32'sh80000000;
    localparam logic signed [VALUE_BITS-1:0] VNEG = 32'shFFFFFFFF;
    localparam logic signed [VALUE_BITS-1:0] VONE = 32'sh00000001;

    typedef bit [63:0] u64_t;

    typedef struct {
        logic signed [VALUE_BITS-1:0] value;
        logic                         oor;
    } grid_result_t;

    typedef struct {
        bit                           is_cfg;
        cfg_idx_t                     cfg_reg;
        cfg_val_t                     cfg_val;
        mode_t                        op;
        logic [POS_BITS-1:0]          px;
        logic [POS_BITS-1:0]          py;
        logic [POS_BITS-1:0]          pz;
        logic signed [VALUE_BITS-1:0] value;
        bit                           typed;
        logic signed [VALUE_BITS-1:0] exp_value;
        logic                         exp_oor;
    } stim_row_t;

    // DUT signals
    logic                         clk;
    logic                         rst_n;
    logic                         start;
    logic                         busy;
    mode_t                        mode;
    logic [POS_BITS-1:0]          pos_x;
    logic [POS_BITS-1:0]          pos_y;
    logic [POS_BITS-1:0]          pos_z;
    logic signed [VALUE_BITS-1:0] deposit_value;
    logic                         done;
    logic signed [VALUE_BITS-1:0] interp_value;
    logic                         out_of_range;
    logic                         cfg_we;
    cfg_idx_t                     cfg_index;
    cfg_val_t                     cfg_data;

    // Local copy of the node store and grid registers
    longint       grid_nodes [STORE_DEPTH];
    cfg_val_t     grid_cfg [3];
    grid_result_t expected_results [$];
    int           error_count;
    int           idle_cycles;

    // Directed table: typed expectations only where obvious
    stim_row_t directed_rows [30] = '{
        '{1'b0, REG_NODES_X, 5'd0, MODE_INTERP,  ORIGIN, ORIGIN, ORIGIN, V0,   1'b1, V0,   1'b0},
        '{1'b0, REG_NODES_X, 5'd0, MODE_DEPOSIT, ORIGIN, ORIGIN, ORIGIN, VMAX, 1'b1, V0,   1'b0},
        '{1'b0, REG_NODES_X, 5'd0, MODE_INTERP,  ORIGIN, ORIGIN, ORIGIN, V0,   1'b1, VMAX, 1'b0},
        '{1'b0, REG_NODES_X, 5'd0, MODE_DEPOSIT, ORIGIN, ORIGIN, ORIGIN, VMAX, 1'b1, V0,   1'b0},
        '{1'b0, REG_NODES_X, 5'd0, MODE_INTERP,  ORIGIN, ORIGIN, ORIGIN, V0,   1'b1, VMAX, 1'b0},
        '{1'b0, REG_NODES_X, 5'd0, MODE_DEPOSIT, MID,    MID,    MID,    VMIN, 1'b0, V0,   1'b0},
        '{1'b0, REG_NODES_X, 5'd0, MODE_INTERP,  MID,    MID,    MID,    V0,   1'b0, V0,   1'b0},
        '{1'b0, REG_NODES_X, 5'd0, MODE_DEPOSIT, PMAX,   PMAX,   PMAX,   VNEG, 1'b0, V0,   1'b0},
        '{1'b0, REG_NODES_X, 5'd0, MODE_INTERP,  PMAX,   PMAX,   PMAX,   V0,   1'b0, V0,   1'b0},
        '{1'b0, REG_NODES_X, 5'd0, MODE_DEPOSIT, NEAR_ONE, 20'h18000, 20'h00001, VONE,
          1'b0, V0, 1'b0},
        '{1'b0, REG_NODES_X, 5'd0, MODE_INTERP,  NEAR_ONE, 20'h18000, 20'h00001, V0,
          1'b0, V0, 1'b0},
        '{1'b0, REG_NODES_X, 5'd0, MODE_UNUSED,  PMAX,   PMAX,   PMAX,   VMAX, 1'b1, V0,   1'b0},
        '{1'b0, REG_NODES_X, 5'd0, MODE_CLEAR,   ORIGIN, ORIGIN, ORIGIN, VMIN, 1'b1, V0,   1'b0},
        '{1'b0, REG_NODES_X, 5'd0, MODE_INTERP,  ORIGIN, ORIGIN, ORIGIN, V0,   1'b1, V0,   1'b0},
        '{1'b0, REG_NODES_X, 5'd0, MODE_INTERP,  PMAX,   PMAX,   PMAX,   V0,   1'b1, V0,   1'b0},
        '{1'b1, REG_NODES_X, 5'd2, MODE_DEPOSIT, ORIGIN, ORIGIN, ORIGIN, V0,   1'b0, V0,   1'b0},
        '{1'b0, REG_NODES_X, 5'd0, MODE_INTERP,  ONE_CELL, ORIGIN, ORIGIN, V0, 1'b1, V0,   1'b1},
        '{1'b0, REG_NODES_X, 5'd0, MODE_DEPOSIT, NEAR_ONE, ORIGIN, ORIGIN, VMAX, 1'b0, V0, 1'b0},
        '{1'b1, REG_NODES_Y, 5'd0, MODE_DEPOSIT, ORIGIN, ORIGIN, ORIGIN, V0,   1'b0, V0,   1'b0},
        '{1'b0, REG_NODES_X, 5'd0, MODE_DEPOSIT, ORIGIN, ONE_CELL, ORIGIN, VMAX, 1'b1, V0, 1'b1},
        '{1'b0, REG_NODES_X, 5'd0, MODE_UNUSED,  ORIGIN, ONE_CELL, ORIGIN, V0, 1'b1, V0,   1'b0},
        '{1'b1, REG_NODES_Z, 5'd31, MODE_DEPOSIT, ORIGIN, ORIGIN, ORIGIN, V0,  1'b0, V0,   1'b0},
        '{1'b0, REG_NODES_X, 5'd0, MODE_INTERP,  NEAR_ONE, NEAR_ONE, PMAX, V0, 1'b0, V0,   1'b0},
        '{1'b1, REG_UNUSED,  5'd31, MODE_DEPOSIT, ORIGIN, ORIGIN, ORIGIN, V0,  1'b0, V0,   1'b0},
        '{1'b1, REG_NODES_X, 5'd1, MODE_DEPOSIT, ORIGIN, ORIGIN, ORIGIN, V0,   1'b0, V0,   1'b0},
        '{1'b0, REG_NODES_X, 5'd0, MODE_INTERP,  NEAR_ONE, ORIGIN, ORIGIN, V0, 1'b0, V0,   1'b0},
        '{1'b1, REG_NODES_X, 5'd17, MODE_DEPOSIT, ORIGIN, ORIGIN, ORIGIN, V0,  1'b0, V0,   1'b0},
        '{1'b1, REG_NODES_Y, 5'd16, MODE_DEPOSIT, ORIGIN, ORIGIN, ORIGIN, V0,  1'b0, V0,   1'b0},
        '{1'b0, REG_NODES_X, 5'd0, MODE_DEPOSIT, PMAX,   ORIGIN, PMAX,   VMIN, 1'b0, V0,   1'b0},
        '{1'b0, REG_NODES_X, 5'd0, MODE_INTERP,  PMAX,   ORIGIN, PMAX,   V0,   1'b0, V0,   1'b0}
    };

    // Grid size and sender idling per random phase
    cfg_val_t phase_cfg [NUM_PHASES][3] = '{
        '{5'd16, 5'd16, 5'd16}, '{5'd2, 5'd2, 5'd2}, '{5'd3, 5'd0, 5'd5},
        '{5'd0, 5'd31, 5'd1}, '{5'd17, 5'd4, 5'd9}, '{5'd16, 5'd16, 5'd16},
        '{5'd31, 5'd1, 5'd16}, '{5'd8, 5'd16, 5'd31}
    };
    int phase_idle [NUM_PHASES] = '{0, 54, 0, 14, 54, 0, 14, 54};

    trilinear_grid_deposit_interpolate_top u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .mode          (mode),
        .pos_x         (pos_x),
        .pos_y         (pos_y),
        .pos_z         (pos_z),
        .deposit_value (deposit_value),
        .done          (done),
        .interp_value  (interp_value),
        .out_of_range  (out_of_range),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    // Clock
    initial clk = 1'b0;
    always #HALF_PERIOD clk = ~clk;

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------
    function automatic int unsigned clamp_nodes(input cfg_val_t r);
        if (r < 2) return 2;
        if (r > NODES_DEF) return NODES_DEF;
        return 32'(r);
    endfunction

    function automatic longint saturate_value(input longint x);
        if (x > VAL_HI) return VAL_HI;
        if (x < VAL_LO) return VAL_LO;
        return x;
    endfunction

    // a * w / 2^FRAC, rounded half away from zero
    function automatic longint weight_scale(input longint a, input u64_t w);
        u64_t mag;
        u64_t r;
        mag = (a < 0) ? u64_t'(-a) : u64_t'(a);
        r = (mag >> FRAC) * w
            + (((mag & ((u64_t'(1) << FRAC) - 1)) * w + (u64_t'(1) << (FRAC - 1))) >> FRAC);
        return (a < 0) ? -$signed(r) : $signed(r);
    endfunction

    function automatic void predict_grid(input mode_t op,
                                         input logic [POS_BITS-1:0] px,
                                         input logic [POS_BITS-1:0] py,
                                         input logic [POS_BITS-1:0] pz,
                                         input logic signed [VALUE_BITS-1:0] v,
                                         output logic signed [VALUE_BITS-1:0] res_value,
                                         output logic res_oor);
        int unsigned nx, ny, nz, ix, iy, iz, idx, a, b, g;
        u64_t   wx [2];
        u64_t   wy [2];
        u64_t   wz [2];
        longint acc;
        longint term;
        res_value = '0;
        res_oor   = 1'b0;
        if (op == MODE_CLEAR) begin
            foreach (grid_nodes[i]) grid_nodes[i] = 0;
            return;
        end
        if (op != MODE_DEPOSIT && op != MODE_INTERP) return;
        nx = clamp_nodes(grid_cfg[REG_NODES_X]);
        ny = clamp_nodes(grid_cfg[REG_NODES_Y]);
        nz = clamp_nodes(grid_cfg[REG_NODES_Z]);
        ix = 32'(px >> FRAC);
        iy = 32'(py >> FRAC);
        iz = 32'(pz >> FRAC);
        // upper corner must lie inside the grid in use
        if (ix + 1 >= nx || iy + 1 >= ny || iz + 1 >= nz) begin
            res_oor = 1'b1;
            return;
        end
        wx[1] = u64_t'(px[FRAC-1:0]); wx[0] = (u64_t'(1) << FRAC) - wx[1];
        wy[1] = u64_t'(py[FRAC-1:0]); wy[0] = (u64_t'(1) << FRAC) - wy[1];
        wz[1] = u64_t'(pz[FRAC-1:0]); wz[0] = (u64_t'(1) << FRAC) - wz[1];
        acc = 0;
        for (int c = 0; c < 8; c++) begin
            a = c & 1;
            b = (c >> 1) & 1;
            g = (c >> 2) & 1;
            idx = (ix + a) + (iy + b) * nx + (iz + g) * nx * ny;
            if (op == MODE_DEPOSIT) begin
                term = weight_scale(weight_scale(weight_scale(longint'(v), wx[a]),
                                                 wy[b]), wz[g]);
                grid_nodes[idx] = saturate_value(grid_nodes[idx] + term);
            end
            else begin
                acc += weight_scale(weight_scale(weight_scale(grid_nodes[idx], wx[a]),
                                                 wy[b]), wz[g]);
            end
        end
        if (op == MODE_INTERP) res_value = VALUE_BITS'(saturate_value(acc));
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers (called at a falling edge, return at a falling edge)
    // ------------------------------------------------------------------
    task automatic issue_command(input mode_t op,
                                 input logic [POS_BITS-1:0] px,
                                 input logic [POS_BITS-1:0] py,
                                 input logic [POS_BITS-1:0] pz,
                                 input logic signed [VALUE_BITS-1:0] v,
                                 input bit typed,
                                 input logic signed [VALUE_BITS-1:0] t_value,
                                 input logic t_oor,
                                 output bit ignored);
        grid_result_t want;
        start         = 1'b1;
        mode          = op;
        pos_x         = px;
        pos_y         = py;
        pos_z         = pz;
        deposit_value = v;
        // wait for the accepting edge
        do @(posedge clk); while (busy);
        predict_grid(op, px, py, pz, v, want.value, want.oor);
        ignored = (op == MODE_UNUSED) || want.oor;
        if (typed) begin
            want.value = t_value;
            want.oor   = t_oor;
        end
        expected_results = {expected_results, want};
        @(negedge clk);
    endtask

    task automatic write_register(input cfg_idx_t idx, input cfg_val_t val);
        start = 1'b0;
        while (expected_results.size() != 0 || busy) @(negedge clk);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        if (idx != REG_UNUSED) grid_cfg[idx] = val;
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    function automatic logic [POS_BITS-1:0] pick_pos(input int unsigned neff,
                                                     input bit beyond);
        int unsigned     cell_idx;
        logic [FRAC-1:0] frac;
        if (beyond) cell_idx = $urandom_range(14, neff - 1);
        else        cell_idx = $urandom_range(0, neff - 2);
        case ($urandom_range(0, 9))
            0, 1:    frac = '0;
            2:       frac = '1;
            3:       frac = 16'h8000;
            4:       frac = 16'h7FFF;
            default: frac = FRAC'($urandom);
        endcase
        return {cell_idx[CELL_BITS-1:0], frac};
    endfunction

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------
    task automatic report_mismatch(input string what);
        $display("MISMATCH at %0t: %s", $realtime, what);
        error_count++;
    endtask

    always @(posedge clk) begin
        grid_result_t want;
        if (rst_n && done === 1'b1) begin
            if (expected_results.size() == 0) begin
                report_mismatch("result transaction with no command pending");
            end
            else begin
                want = expected_results.pop_front();
                if (interp_value !== want.value)
                    report_mismatch($sformatf("interp_value %0d, expected %0d",
                                              interp_value, want.value));
                if (out_of_range !== want.oor)
                    report_mismatch($sformatf("out_of_range %0b, expected %0b",
                                              out_of_range, want.oor));
            end
        end
    end

    // Watchdog: cycles without any transaction
    always @(posedge clk) begin
        if ((start && !busy) || done === 1'b1) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
    end

    initial begin
        while (idle_cycles < WATCHDOG_LIMIT) @(posedge clk);
        $display("Timeout: no transaction for %0d cycles", WATCHDOG_LIMIT);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        int unsigned eff [3];
        logic [POS_BITS-1:0] px, py, pz;
        logic signed [VALUE_BITS-1:0] v;
        mode_t op;
        int    oor_axis;
        int    counted;
        int    gap;
        bit    ignored;

        error_count   = 0;
        idle_cycles   = 0;
        rst_n         = 1'b0;
        start         = 1'b0;
        mode          = MODE_DEPOSIT;
        pos_x         = '0;
        pos_y         = '0;
        pos_z         = '0;
        deposit_value = '0;
        cfg_we        = 1'b0;
        cfg_index     = REG_NODES_X;
        cfg_data      = '0;
        foreach (grid_nodes[i]) grid_nodes[i] = 0;
        foreach (grid_cfg[i]) grid_cfg[i] = NODES_RESET;

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed table
        foreach (directed_rows[r]) begin
            if (directed_rows[r].is_cfg)
                write_register(directed_rows[r].cfg_reg, directed_rows[r].cfg_val);
            else
                issue_command(directed_rows[r].op, directed_rows[r].px,
                              directed_rows[r].py, directed_rows[r].pz,
                              directed_rows[r].value, directed_rows[r].typed,
                              directed_rows[r].exp_value, directed_rows[r].exp_oor,
                              ignored);
        end

        // Random phases
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            if (ph == 5) begin
                for (int k = 0; k < 3; k++)
                    phase_cfg[ph][k] = cfg_val_t'($urandom_range(0, 31));
            end
            write_register(REG_NODES_X, phase_cfg[ph][0]);
            write_register(REG_NODES_Y, phase_cfg[ph][1]);
            write_register(REG_NODES_Z, phase_cfg[ph][2]);
            eff[0] = clamp_nodes(grid_cfg[REG_NODES_X]);
            eff[1] = clamp_nodes(grid_cfg[REG_NODES_Y]);
            eff[2] = clamp_nodes(grid_cfg[REG_NODES_Z]);
            px = ORIGIN;
            py = ORIGIN;
            pz = ORIGIN;
            counted = 0;
            while (counted < ITEMS_PER_PHASE) begin
                // sender gap, now and then long enough to outlast a command
                if ($urandom_range(0, 99) < phase_idle[ph]) begin
                    gap = ($urandom_range(0, 3) == 0) ? $urandom_range(4, 60)
                                                      : $urandom_range(1, 3);
                    start = 1'b0;
                    repeat (gap) @(negedge clk);
                end

                case ($urandom_range(0, 99)) inside
                    [0:0]:   op = MODE_CLEAR;
                    [1:3]:   op = MODE_UNUSED;
                    [4:49]:  op = MODE_DEPOSIT;
                    default: op = MODE_INTERP;
                endcase

                // mostly fresh in-grid positions, some repeats to pile up sums
                oor_axis = ($urandom_range(0, 99) < 8) ? $urandom_range(0, 2) : 3;
                if (oor_axis != 3 || $urandom_range(0, 99) >= 30) begin
                    px = pick_pos(eff[0], oor_axis == 0 && eff[0] < NODES_DEF);
                    py = pick_pos(eff[1], oor_axis == 1 && eff[1] < NODES_DEF);
                    pz = pick_pos(eff[2], oor_axis == 2 && eff[2] < NODES_DEF);
                end

                case ($urandom_range(0, 3))
                    0: begin
                        case ($urandom_range(0, 4))
                            0:       v = VMAX;
                            1:       v = VMIN;
                            2:       v = VNEG;
                            3:       v = VONE;
                            default: v = V0;
                        endcase
                    end
                    1:       v = $signed($urandom_range(0, 2000)) - 1000;
                    default: v = $urandom;
                endcase

                issue_command(op, px, py, pz, v, 1'b0, V0, 1'b0, ignored);
                if (!ignored) counted++;
            end
        end

        // Drain
        start = 1'b0;
        while (expected_results.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

>>> trilinear_grid_deposit_interpolate_top.f
sv/tgdi_pkg.sv
sv/trilinear_grid_deposit_interpolate_top.sv
test/trilinear_grid_deposit_interpolate_top_tb.sv
